// ===== sv/rpab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpab_pkg
// Shared types and constants of the rectilinear path area and bounding box
// block.
// ----------------------------------------------------------------------------
package rpab_pkg;

  localparam int CoordW     = 25;
  localparam int OpW        = CoordW + 1;
  localparam int SumW       = 50;
  localparam int AreaW      = 49;
  localparam int LenW       = 16;
  localparam int DirW       = 2;
  localparam int CntOutW    = 9;
  localparam int CntOutMax  = 511;
  localparam int MinForArea = 4;

  localparam int InPackW   = DirW + LenW;
  localparam int InDataW   = ((InPackW + 7) / 8) * 8;
  localparam int OutPackW  = AreaW + 4 * CoordW + CntOutW;
  localparam int OutDataW  = ((OutPackW + 7) / 8) * 8;

  typedef enum logic [DirW-1:0] {
    DirRight = 2'd0,
    DirLeft  = 2'd1,
    DirUp    = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  typedef struct packed {
    logic                     ovf;
    logic                     short_path;
    logic [CntOutW-1:0]       seg;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_x;
  } result_meta_t;

endpackage

// ===== sv/rectilinear_path_area_bbox.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectilinear_path_area_bbox
// Walks a rectilinear outline from the origin, accumulates the shoelace sum
// and the bounding box, and reports twice the area on the final move.
// ----------------------------------------------------------------------------
//  channel   dir  transaction                   tdata (low bit up)           tuser
//  s_axis    in   one move                      direction, length            -
//  m_axis    out  one result per final move     twice_area, box_min_x,       overflowed
//                                               box_max_x, box_min_y,
//                                               box_max_y, segment_total
//
//  One move per clock unless a final move waits on a full output register.
//  Stages: input register, position update, multiply, accumulate/output.
//  Reset clears the point, sum, count and box at once; no clearing pass.
//  Only a final move waits on a full output register; other moves drain.
// ----------------------------------------------------------------------------
module rectilinear_path_area_bbox #(
  parameter int MAX_MOVES   = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // direction[1:0], length[17:2], zero pad
  input  logic [rpab_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // twice_area[48:0], box_min_x[73:49], box_max_x[98:74], box_min_y[123:99],
  // box_max_y[148:124], segment_total[157:149], zero pad
  output logic [rpab_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // overflowed[0]
  output logic                           m_axis_tuser_o
);
  import rpab_pkg::*;

  localparam int CntW     = $clog2(MAX_MOVES + 1);
  localparam int CntExtW  = (CntW > CntOutW) ? CntW : CntOutW;
  localparam int LenUseW  = (LENGTH_BITS < LenW) ? LENGTH_BITS : LenW;

  // input register
  logic             in_vld_q;
  dir_e             in_dir_q;
  logic [LenW-1:0]  in_len_q;
  logic             in_last_q;

  // walk state
  logic signed [CoordW-1:0] cur_x_q, cur_y_q;
  logic signed [CoordW-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
  logic [CntW-1:0]          moves_q;
  logic                     ovf_q;
  logic signed [SumW-1:0]   sum_q;

  // operand stage
  logic                     op_vld_q, op_last_q, op_pv_q;
  logic signed [OpW-1:0]    op_a_q, op_b_q;
  result_meta_t             op_meta_q;

  // product stage
  logic                     prod_vld_q, prod_last_q, prod_pv_q;
  logic [SumW-1:0]          prod_q;
  result_meta_t             prod_meta_q;

  // output register
  logic                     out_vld_q;
  logic [AreaW-1:0]         out_area_q;
  result_meta_t             out_meta_q;

  logic en_in, en_op, en_prod, out_free, step;

  logic                     room, x_move;
  logic signed [CoordW-1:0] len_c, ex, ey;
  logic signed [CoordW-1:0] nlow_x, nhigh_x, nlow_y, nhigh_y;
  logic [CntW-1:0]          fin_cnt;
  logic [CntExtW-1:0]       cnt_ext;
  logic signed [OpW-1:0]    op_a_d, op_b_d;
  logic signed [2*OpW-1:0]  prod_full;
  logic [SumW-1:0]          sum_abs;
  result_meta_t             meta_d;

  // handshake chain
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign en_prod  = !prod_vld_q || !prod_last_q || out_free;
  assign en_op    = !op_vld_q || en_prod;
  assign en_in    = !in_vld_q || en_op;
  assign step     = in_vld_q && en_op;

  assign s_axis_tready_o = en_in;

  // position update
  always_comb begin
    room   = moves_q < CntW'(MAX_MOVES);
    len_c  = CoordW'(in_len_q[LenUseW-1:0]);
    ex     = cur_x_q;
    ey     = cur_y_q;
    x_move = 1'b0;
    unique case (in_dir_q)
      DirRight: begin
        ex     = cur_x_q + len_c;
        x_move = 1'b1;
      end
      DirLeft: begin
        ex     = cur_x_q - len_c;
        x_move = 1'b1;
      end
      DirUp:    ey = cur_y_q - len_c;
      DirDown:  ey = cur_y_q + len_c;
      default:  ey = cur_y_q;
    endcase

    nlow_x  = (ex < low_x_q)  ? ex : low_x_q;
    nhigh_x = (ex > high_x_q) ? ex : high_x_q;
    nlow_y  = (ey < low_y_q)  ? ey : low_y_q;
    nhigh_y = (ey > high_y_q) ? ey : high_y_q;

    if (x_move) begin
      op_a_d = OpW'(cur_x_q) - OpW'(ex);
      op_b_d = OpW'(cur_y_q);
    end else begin
      op_a_d = OpW'(cur_x_q);
      op_b_d = OpW'(ey) - OpW'(cur_y_q);
    end

    fin_cnt = room ? (moves_q + CntW'(1)) : moves_q;
    cnt_ext = CntExtW'(fin_cnt);

    meta_d.ovf        = ovf_q || !room;
    meta_d.short_path = fin_cnt < CntW'(MinForArea);
    meta_d.seg        = (cnt_ext > CntExtW'(CntOutMax)) ? CntOutW'(CntOutMax)
                                                         : cnt_ext[CntOutW-1:0];
    meta_d.min_x      = room ? nlow_x  : low_x_q;
    meta_d.max_x      = room ? nhigh_x : high_x_q;
    meta_d.min_y      = room ? nlow_y  : low_y_q;
    meta_d.max_y      = room ? nhigh_y : high_y_q;
  end

  assign prod_full = op_a_q * op_b_q;
  assign sum_abs   = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;

  // control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      op_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      low_x_q     <= '0;
      high_x_q    <= '0;
      low_y_q     <= '0;
      high_y_q    <= '0;
      moves_q     <= '0;
      ovf_q       <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (en_in) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (en_op) begin
        op_vld_q <= in_vld_q;
      end
      if (en_prod) begin
        prod_vld_q <= op_vld_q;
      end

      if (prod_vld_q && prod_last_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      if (prod_vld_q && en_prod) begin
        if (prod_last_q) begin
          sum_q <= '0;
        end else if (prod_pv_q) begin
          sum_q <= sum_q + signed'(prod_q);
        end
      end

      if (step) begin
        priority if (in_last_q) begin
          cur_x_q  <= '0;
          cur_y_q  <= '0;
          low_x_q  <= '0;
          high_x_q <= '0;
          low_y_q  <= '0;
          high_y_q <= '0;
          moves_q  <= '0;
          ovf_q    <= 1'b0;
        end else if (room) begin
          cur_x_q  <= ex;
          cur_y_q  <= ey;
          low_x_q  <= nlow_x;
          high_x_q <= nhigh_x;
          low_y_q  <= nlow_y;
          high_y_q <= nhigh_y;
          moves_q  <= fin_cnt;
        end else begin
          ovf_q    <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_in && s_axis_tvalid_i) begin
      in_dir_q  <= dir_e'(s_axis_tdata_i[DirW-1:0]);
      in_len_q  <= s_axis_tdata_i[DirW+LenW-1:DirW];
      in_last_q <= s_axis_tlast_i;
    end
    if (step) begin
      op_last_q <= in_last_q;
      op_pv_q   <= room && !in_last_q;
      op_a_q    <= op_a_d;
      op_b_q    <= op_b_d;
      op_meta_q <= meta_d;
    end
    if (en_prod && op_vld_q) begin
      prod_last_q <= op_last_q;
      prod_pv_q   <= op_pv_q;
      prod_q      <= prod_full[SumW-1:0];
      prod_meta_q <= op_meta_q;
    end
    if (prod_vld_q && prod_last_q && out_free) begin
      out_area_q <= prod_meta_q.short_path ? '0 : sum_abs[AreaW-1:0];
      out_meta_q <= prod_meta_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_meta_q.ovf;
  assign m_axis_tdata_o  = {{(OutDataW-OutPackW){1'b0}}, out_meta_q.seg,
                            out_meta_q.max_y, out_meta_q.min_y,
                            out_meta_q.max_x, out_meta_q.min_x, out_area_q};

  a_last_no_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q && prod_last_q |-> !prod_pv_q)
    else $error("final move carries a cross product");

  a_short_zero_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_meta_q.seg < CntOutW'(MinForArea)) |-> out_area_q == '0)
    else $error("short outline reports nonzero area");

  a_box_has_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_meta_q.min_x <= 0) && (out_meta_q.max_x >= 0) &&
                  (out_meta_q.min_y <= 0) && (out_meta_q.max_y >= 0))
    else $error("bounding box excludes the origin");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> int'(out_meta_q.seg) <= MAX_MOVES)
    else $error("segment count above limit");

  a_walk_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> (moves_q == '0) && !ovf_q && (cur_x_q == '0))
    else $error("walk state not cleared after final move");

endmodule
